[design/cau_pkg.sv]
`default_nettype none
package cau_pkg;

	// word format
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int PROD_BITS = 2 * WORD_BITS;
	localparam int WIDE_BITS = PROD_BITS + 2;

	// angle unit: 2^-30 rad
	localparam int ANG_FRAC = 30;
	localparam int ANG_SHIFT = ANG_FRAC - FRAC_BITS;
	localparam int CORDIC_STEPS = 32;
	localparam int CW = WORD_BITS + 3;
	localparam int ZW = WORD_BITS + 2;
	localparam logic [ZW-1:0] PI_A = 34'd3373259426;
	localparam logic [ZW-1:0] HALF_PI_A = 34'd1686629713;
	localparam logic [7:0] DEG_HALF_TURN = 8'd180;

	// divider: quotient bits kept before the result is known to saturate
	localparam int QW = WORD_BITS + 1;
	localparam int DIV_STEPS = QW;
	localparam int SQRT_STEPS = WORD_BITS;
	localparam int MW = QW + 1;

	// operation codes
	localparam logic [3:0] OP_ADD = 4'd0;
	localparam logic [3:0] OP_SUB = 4'd1;
	localparam logic [3:0] OP_MUL = 4'd2;
	localparam logic [3:0] OP_DIV = 4'd3;
	localparam logic [3:0] OP_NEG = 4'd4;
	localparam logic [3:0] OP_SQR = 4'd5;
	localparam logic [3:0] OP_RCP = 4'd6;
	localparam logic [3:0] OP_MOD = 4'd7;
	localparam logic [3:0] OP_RAD = 4'd8;
	localparam logic [3:0] OP_DEG = 4'd9;
	localparam logic [3:0] OP_EQ = 4'd10;
	localparam logic [3:0] OP_NE = 4'd11;

	// status codes
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DZ = 2'd1;
	localparam logic [1:0] ST_AZ = 2'd2;
	localparam logic [1:0] ST_SAT = 2'd3;

	localparam logic [WORD_BITS-1:0] LIM_POS = 32'h7FFFFFFF;
	localparam logic [WORD_BITS-1:0] LIM_NEG = 32'h80000000;
	localparam logic signed [WIDE_BITS-1:0] WMAX = 66'sd2147483647;
	localparam logic signed [WIDE_BITS-1:0] WMIN = -66'sd2147483648;
	localparam logic [MW-1:0] MAG_POS = 34'd2147483647;
	localparam logic [MW-1:0] MAG_NEG = 34'd2147483648;

	// atan(2^-i) in 2^-30 rad
	localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// payload that travels along the pipe
	typedef struct packed {
		logic [3:0]           op;
		logic [WORD_BITS-1:0] rre;
		logic [WORD_BITS-1:0] rim;
		logic                 sat;
		logic                 cmp;
		logic [1:0]           st;
		logic                 re_zero;
		logic                 re_neg;
		logic                 im_pos;
		logic                 nre;
		logic                 nim;
		logic [PROD_BITS-1:0] ure;
		logic [PROD_BITS-1:0] uim;
		logic [PROD_BITS-1:0] den;
	} cau_side_t;

	// clamp a signed value to the word: {saturated, word}
	function automatic logic [WORD_BITS:0] clamp_s(input logic signed [WIDE_BITS-1:0] v);
		logic [WORD_BITS:0] r;
		if (v > WMAX) r = {1'b1, LIM_POS};
		else if (v < WMIN) r = {1'b1, LIM_NEG};
		else r = {1'b0, v[WORD_BITS-1:0]};
		return r;
	endfunction

	// clamp sign and magnitude to the word: {saturated, word}
	function automatic logic [WORD_BITS:0] clamp_m(input logic neg, input logic [MW-1:0] mag);
		logic [MW-1:0] t;
		logic [WORD_BITS:0] r;
		t = '0 - mag;
		if (!neg) begin
			if (mag > MAG_POS) r = {1'b1, LIM_POS};
			else r = {1'b0, mag[WORD_BITS-1:0]};
		end else begin
			if (mag > MAG_NEG) r = {1'b1, LIM_NEG};
			else r = {1'b0, t[WORD_BITS-1:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[design/cau_cordic.sv]
`default_nettype none
module cau_cordic import cau_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire cau_side_t            in_side,
	input  wire logic signed [CW-1:0] in_x,
	input  wire logic signed [CW-1:0] in_y,
	output logic                      out_valid,
	output cau_side_t                 out_side,
	output logic signed [ZW-1:0]      out_z
);

	logic                 v_s    [CORDIC_STEPS];
	cau_side_t            side_s [CORDIC_STEPS];
	logic signed [CW-1:0] x_s    [CORDIC_STEPS];
	logic signed [CW-1:0] y_s    [CORDIC_STEPS];
	logic signed [ZW-1:0] z_s    [CORDIC_STEPS];

	// one vectoring rotation per stage
	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
		logic                 vi;
		cau_side_t            si;
		logic signed [CW-1:0] xi, yi, xsh, ysh;
		logic signed [ZW-1:0] zi, at;

		if (i == 0) begin : g_first
			assign vi = in_valid;
			assign si = in_side;
			assign xi = in_x;
			assign yi = in_y;
			assign zi = '0;
		end else begin : g_next
			assign vi = v_s[i-1];
			assign si = side_s[i-1];
			assign xi = x_s[i-1];
			assign yi = y_s[i-1];
			assign zi = z_s[i-1];
		end

		assign xsh = xi >>> i;
		assign ysh = yi >>> i;
		assign at  = $signed(ZW'(ATAN_TAB[i]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= vi;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[i] <= si;
				if (!yi[CW-1]) begin
					x_s[i] <= xi + ysh;
					y_s[i] <= yi - xsh;
					z_s[i] <= zi + at;
				end else begin
					x_s[i] <= xi - ysh;
					y_s[i] <= yi + xsh;
					z_s[i] <= zi - at;
				end
			end
		end
	end

	assign out_valid = v_s[CORDIC_STEPS-1];
	assign out_side  = side_s[CORDIC_STEPS-1];
	assign out_z     = z_s[CORDIC_STEPS-1];

endmodule
`default_nettype wire

[design/cau_div.sv]
`default_nettype none
module cau_div import cau_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire cau_side_t       in_side,
	output logic                 out_valid,
	output cau_side_t            out_side,
	output logic [QW-1:0]        out_qre,
	output logic [QW-1:0]        out_qim,
	output logic                 out_ovr_re,
	output logic                 out_ovr_im,
	output logic [PROD_BITS-1:0] out_root
);

	localparam int OVW = PROD_BITS + QW - FRAC_BITS;

	logic                 v_s      [DIV_STEPS+1];
	cau_side_t            side_s   [DIV_STEPS+1];
	logic [PROD_BITS-1:0] rre_s    [DIV_STEPS+1];
	logic [PROD_BITS-1:0] rim_s    [DIV_STEPS+1];
	logic [QW-1:0]        qre_s    [DIV_STEPS+1];
	logic [QW-1:0]        qim_s    [DIV_STEPS+1];
	logic                 ovre_s   [DIV_STEPS+1];
	logic                 ovim_s   [DIV_STEPS+1];
	logic [PROD_BITS-1:0] n_s      [DIV_STEPS+1];
	logic [PROD_BITS-1:0] root_s   [DIV_STEPS+1];
	logic [OVW-1:0]       den_sh;

	// entry: overflow check and top part of the shifted dividend
	assign den_sh = {in_side.den, (QW - FRAC_BITS)'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s[0] <= 1'b0;
		else if (en) v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= in_side;
			ovre_s[0] <= OVW'(in_side.ure) >= den_sh;
			ovim_s[0] <= OVW'(in_side.uim) >= den_sh;
			rre_s[0]  <= in_side.ure >> (QW - FRAC_BITS);
			rim_s[0]  <= in_side.uim >> (QW - FRAC_BITS);
			qre_s[0]  <= '0;
			qim_s[0]  <= '0;
			n_s[0]    <= in_side.ure;
			root_s[0] <= '0;
		end
	end

	// one quotient bit per lane per stage, and one root bit in each of the first SQRT_STEPS stages
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		localparam int J = QW - 1 - k;
		logic                 bre, bim;
		logic [PROD_BITS:0]   tre, tim, dd;
		logic [PROD_BITS-1:0] nn, rn;

		if (J >= FRAC_BITS) begin : g_bit
			assign bre = side_s[k].ure[J-FRAC_BITS];
			assign bim = side_s[k].uim[J-FRAC_BITS];
		end else begin : g_zero
			assign bre = 1'b0;
			assign bim = 1'b0;
		end

		assign tre = {rre_s[k], bre};
		assign tim = {rim_s[k], bim};
		assign dd  = {1'b0, side_s[k].den};

		// restoring square root step
		if (k < SQRT_STEPS) begin : g_sqrt
			logic [PROD_BITS-1:0] sb, sr;
			assign sb = PROD_BITS'(1) << (PROD_BITS - 2 - 2 * k);
			assign sr = root_s[k] + sb;
			always_comb begin
				if (n_s[k] >= sr) begin
					nn = n_s[k] - sr;
					rn = (root_s[k] >> 1) + sb;
				end else begin
					nn = n_s[k];
					rn = root_s[k] >> 1;
				end
			end
		end else begin : g_hold
			assign nn = n_s[k];
			assign rn = root_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[k+1] <= 1'b0;
			else if (en) v_s[k+1] <= v_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[k+1] <= side_s[k];
				ovre_s[k+1] <= ovre_s[k];
				ovim_s[k+1] <= ovim_s[k];
				n_s[k+1]    <= nn;
				root_s[k+1] <= rn;
				if (tre >= dd) begin
					rre_s[k+1] <= PROD_BITS'(tre - dd);
					qre_s[k+1] <= {qre_s[k][QW-2:0], 1'b1};
				end else begin
					rre_s[k+1] <= PROD_BITS'(tre);
					qre_s[k+1] <= {qre_s[k][QW-2:0], 1'b0};
				end
				if (tim >= dd) begin
					rim_s[k+1] <= PROD_BITS'(tim - dd);
					qim_s[k+1] <= {qim_s[k][QW-2:0], 1'b1};
				end else begin
					rim_s[k+1] <= PROD_BITS'(tim);
					qim_s[k+1] <= {qim_s[k][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid  = v_s[DIV_STEPS];
	assign out_side   = side_s[DIV_STEPS];
	assign out_qre    = qre_s[DIV_STEPS];
	assign out_qim    = qim_s[DIV_STEPS];
	assign out_ovr_re = ovre_s[DIV_STEPS];
	assign out_ovr_im = ovim_s[DIV_STEPS];
	assign out_root   = root_s[DIV_STEPS];

endmodule
`default_nettype wire

[design/complex_arithmetic_unit.sv]
// Throughput: one item per cycle while the output is not stalled; the 32-stage CORDIC and the 33-step radix-2
// divider (which also runs the square root) are fully pipelined.
// A stall on the output freezes the whole pipe; nothing is lost or repeated.
// Reset (arst_n low) clears all valid bits, the output valid among them, at once.
`default_nettype none
module complex_arithmetic_unit import cau_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  wire logic [3:0]   s_axis_tuser,  // req_type
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [63:0]       m_axis_tdata,  // res_re, res_im
	output logic [2:0]        m_axis_tuser   // compare_true, status
);

	logic en;

	// stage 1: input register
	logic                        v_s1;
	logic [3:0]                  op_s1;
	logic signed [WORD_BITS-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products
	logic                        v_s2;
	cau_side_t                   side_s2;
	logic signed [PROD_BITS-1:0] p1_s2, p2_s2, p3_s2, p4_s2, d1_s2, d2_s2;
	logic                        bz_s2, az_s2;
	logic signed [CW-1:0]        cx_s2, cy_s2;

	// stage 3: sums
	logic                        v_s3;
	cau_side_t                   side_s3;
	logic signed [CW-1:0]        cx_s3, cy_s3;

	// after CORDIC
	logic                        cv;
	cau_side_t                   cside;
	logic signed [ZW-1:0]        cz;
	logic                        v_s4;
	cau_side_t                   side_s4;
	logic signed [ZW-1:0]        ang_s4;
	logic                        v_s5;
	cau_side_t                   side_s5;

	// after divider
	logic                        dv;
	cau_side_t                   dside;
	logic [QW-1:0]               dqre, dqim;
	logic                        dovre, dovim;
	logic [PROD_BITS-1:0]        droot;

	// output register
	logic                        m_valid_q;
	logic [WORD_BITS-1:0]        res_re_q, res_im_q;
	logic                        cmp_q;
	logic [1:0]                  st_q;

	// combinational
	logic signed [WORD_BITS-1:0] xr, xi, yr, yi;
	cau_side_t                   s2_n, s3_n, s5_n;
	logic [WORD_BITS:0]          c_re, c_im;
	logic [WORD_BITS:0]          mc_re, mc_im, rc_re;
	logic signed [WIDE_BITS-1:0] mr, mi, nr, ni;
	logic [WIDE_BITS-1:0]        nr_mag, ni_mag;
	logic signed [ZW-1:0]        ang_n;
	logic                        a_neg;
	logic [ZW-1:0]               a_mag;
	logic [ZW-1:0]               a_rnd;
	logic [ZW-ANG_SHIFT-1:0]     a_rad;
	logic [WORD_BITS:0]          f_re, f_im;
	logic [1:0]                  f_st;

	assign en            = !m_valid_q || m_axis_tready;
	assign s_axis_tready = en;

	// stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_axis_tuser;
			ar_s1 <= s_axis_tdata[31:0];
			ai_s1 <= s_axis_tdata[63:32];
			br_s1 <= s_axis_tdata[95:64];
			bi_s1 <= s_axis_tdata[127:96];
		end
	end

	// operand routing and the simple operations
	always_comb begin
		xr = ar_s1;
		xi = ai_s1;
		yr = br_s1;
		yi = bi_s1;
		case (op_s1)
			OP_SQR, OP_MOD: begin
				yr = ar_s1;
				yi = ai_s1;
			end
			OP_RCP: begin
				xr = WORD_BITS'(1) <<< FRAC_BITS;
				xi = '0;
				yr = ar_s1;
				yi = ai_s1;
			end
			default: ;
		endcase

		s2_n         = '0;
		s2_n.op      = op_s1;
		s2_n.re_zero = ar_s1 == '0;
		s2_n.re_neg  = ar_s1 < 0;
		s2_n.im_pos  = ai_s1 > 0;
		c_re         = '0;
		c_im         = '0;
		case (op_s1)
			OP_ADD: begin
				c_re = clamp_s(WIDE_BITS'(ar_s1) + WIDE_BITS'(br_s1));
				c_im = clamp_s(WIDE_BITS'(ai_s1) + WIDE_BITS'(bi_s1));
			end
			OP_SUB: begin
				c_re = clamp_s(WIDE_BITS'(ar_s1) - WIDE_BITS'(br_s1));
				c_im = clamp_s(WIDE_BITS'(ai_s1) - WIDE_BITS'(bi_s1));
			end
			OP_NEG: begin
				c_re = clamp_s(-WIDE_BITS'(ar_s1));
				c_im = clamp_s(-WIDE_BITS'(ai_s1));
			end
			OP_EQ: s2_n.cmp = (ar_s1 == br_s1) && (ai_s1 == bi_s1);
			OP_NE: s2_n.cmp = (ar_s1 != br_s1) || (ai_s1 != bi_s1);
			default: ;
		endcase
		s2_n.rre = c_re[WORD_BITS-1:0];
		s2_n.rim = c_im[WORD_BITS-1:0];
		s2_n.sat = c_re[WORD_BITS] | c_im[WORD_BITS];
	end

	// stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= s2_n;
			p1_s2   <= xr * yr;
			p2_s2   <= xi * yi;
			p3_s2   <= xr * yi;
			p4_s2   <= xi * yr;
			d1_s2   <= yr * yr;
			d2_s2   <= yi * yi;
			bz_s2   <= (yr == '0) && (yi == '0);
			az_s2   <= (ar_s1 == '0) && (ai_s1 == '0);
			cx_s2   <= (ar_s1 > 0) ? CW'(ar_s1) : -CW'(ar_s1);
			cy_s2   <= (ar_s1 > 0) ? CW'(ai_s1) : -CW'(ai_s1);
		end
	end

	// sums of products
	always_comb begin
		mr     = WIDE_BITS'(p1_s2) - WIDE_BITS'(p2_s2);
		mi     = WIDE_BITS'(p3_s2) + WIDE_BITS'(p4_s2);
		nr     = WIDE_BITS'(p1_s2) + WIDE_BITS'(p2_s2);
		ni     = WIDE_BITS'(p4_s2) - WIDE_BITS'(p3_s2);
		nr_mag = nr[WIDE_BITS-1] ? WIDE_BITS'(-nr) : WIDE_BITS'(nr);
		ni_mag = ni[WIDE_BITS-1] ? WIDE_BITS'(-ni) : WIDE_BITS'(ni);
		s3_n   = side_s2;
		mc_re  = clamp_s(mr >>> FRAC_BITS);
		mc_im  = clamp_s(mi >>> FRAC_BITS);
		case (side_s2.op)
			OP_MUL, OP_SQR: begin
				s3_n.rre = mc_re[WORD_BITS-1:0];
				s3_n.rim = mc_im[WORD_BITS-1:0];
				s3_n.sat = mc_re[WORD_BITS] | mc_im[WORD_BITS];
			end
			OP_DIV, OP_RCP: begin
				if (bz_s2) begin
					s3_n.st = ST_DZ;
				end else begin
					s3_n.nre = nr[WIDE_BITS-1];
					s3_n.nim = ni[WIDE_BITS-1];
					s3_n.ure = nr_mag[PROD_BITS-1:0];
					s3_n.uim = ni_mag[PROD_BITS-1:0];
					s3_n.den = PROD_BITS'($unsigned(d1_s2)) + PROD_BITS'($unsigned(d2_s2));
				end
			end
			OP_MOD: s3_n.ure = nr_mag[PROD_BITS-1:0];
			OP_RAD, OP_DEG: begin
				if (az_s2) s3_n.st = ST_AZ;
			end
			default: ;
		endcase
	end

	// stage 3
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= s3_n;
			cx_s3   <= cx_s2;
			cy_s3   <= cy_s2;
		end
	end

	cau_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_side   (side_s3),
		.in_x      (cx_s3),
		.in_y      (cy_s3),
		.out_valid (cv),
		.out_side  (cside),
		.out_z     (cz)
	);

	// quadrant fix-up of the angle
	always_comb begin
		if (cside.re_zero) ang_n = cside.im_pos ? $signed(HALF_PI_A) : -$signed(HALF_PI_A);
		else if (cside.re_neg) ang_n = cz + $signed(PI_A);
		else ang_n = cz;
	end

	// stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= cv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= cside;
			ang_s4  <= ang_n;
		end
	end

	// radians rounded here, degrees go to the divider
	always_comb begin
		a_neg = ang_s4[ZW-1];
		a_mag = a_neg ? ZW'(-ang_s4) : ZW'(ang_s4);
		a_rnd = a_mag + (ZW'(1) << (ANG_SHIFT - 1));
		a_rad = a_rnd[ZW-1:ANG_SHIFT];
		rc_re = clamp_m(a_neg, MW'(a_rad));
		s5_n  = side_s4;
		if (side_s4.st == ST_OK) begin
			case (side_s4.op)
				OP_RAD: begin
					s5_n.rre = rc_re[WORD_BITS-1:0];
					s5_n.sat = rc_re[WORD_BITS];
				end
				OP_DEG: begin
					s5_n.nre = a_neg;
					s5_n.nim = 1'b0;
					s5_n.ure = PROD_BITS'(a_mag) * PROD_BITS'(DEG_HALF_TURN);
					s5_n.uim = '0;
					s5_n.den = PROD_BITS'(PI_A);
				end
				default: ;
			endcase
		end
	end

	// stage 5
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) side_s5 <= s5_n;
	end

	cau_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (v_s5),
		.in_side    (side_s5),
		.out_valid  (dv),
		.out_side   (dside),
		.out_qre    (dqre),
		.out_qim    (dqim),
		.out_ovr_re (dovre),
		.out_ovr_im (dovim),
		.out_root   (droot)
	);

	// final selection and saturation
	always_comb begin
		f_re = {dside.sat, dside.rre};
		f_im = {1'b0, dside.rim};
		if (dside.st == ST_OK) begin
			case (dside.op)
				OP_DIV, OP_RCP, OP_DEG: begin
					f_re = clamp_m(dside.nre, dovre ? '1 : MW'(dqre));
					f_im = clamp_m(dside.nim, dovim ? '1 : MW'(dqim));
				end
				OP_MOD: f_re = clamp_m(1'b0, droot[MW-1:0]);
				default: ;
			endcase
		end
		if (dside.st != ST_OK) f_st = dside.st;
		else if (f_re[WORD_BITS] || f_im[WORD_BITS] || dside.sat) f_st = ST_SAT;
		else f_st = ST_OK;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (en) m_valid_q <= dv;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= f_re[WORD_BITS-1:0];
			res_im_q <= f_im[WORD_BITS-1:0];
			cmp_q    <= dside.cmp;
			st_q     <= f_st;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {res_im_q, res_re_q};
	assign m_axis_tuser  = {st_q, cmp_q};

endmodule
`default_nettype wire
